FILE: hw/rtl/cpf_pkg.sv
// ----------------------------------------------------------------------------
// cpf_pkg
// Shared types and constants for the command packet framer.
// ----------------------------------------------------------------------------
package cpf_pkg;

    localparam logic [7:0]  HDR_BYTE0  = 8'hEF;
    localparam logic [7:0]  HDR_BYTE1  = 8'h01;
    localparam logic [7:0]  PKT_FLAG   = 8'h01;
    localparam logic [31:0] ADDR_RESET = 32'hFFFF_FFFF;

    // Byte position within a serialized packet
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_HDR0   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_HDR1   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ADDR3  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_ADDR2  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ADDR1  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ADDR0  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_FLAG   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_LEN_HI = 4'd7;
    localparam logic [STEP_W-1:0] STEP_LEN_LO = 4'd8;
    localparam logic [STEP_W-1:0] STEP_BODY   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_CK_HI  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_CK_LO  = 4'd11;

    // One output byte handed from the sequencer to the output register
    typedef struct packed {
        logic [7:0] data;
        logic       pkt_end;
    } beat_t;

endpackage

FILE: hw/rtl/command_packet_framer_core.sv
// ----------------------------------------------------------------------------
// command_packet_framer_core
// Frames command body bytes into packets: header, address, flag, length,
// body and a 16-bit sum checksum.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   in        in_valid/in_ready    body_byte, first_byte, last_byte, packet_length
//   out       out_valid/out_ready  out_byte, packet_end
//   cfg       cfg_wr_en            cfg_wr_data (module address)
//
// One output byte per cycle while the output is not stalled. An item holds the
// sequencer until its bytes are out: header, address, flag and length if it
// opens a packet, the body byte, the checksum if it closes; a discard emits none.
// The next item is taken in the cycle the current one emits its final byte.
// Output stalls hold the output register and back up into the sequencer.
// Reset empties both stages, closes any packet and sets the address to all ones.
// ----------------------------------------------------------------------------
module command_packet_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  body_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [15:0] packet_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        packet_end
);
    import cpf_pkg::*;

    logic [31:0] addr_reg;
    logic        out_valid_reg, out_valid_next;
    logic [7:0]  out_byte_reg;
    logic        packet_end_reg;

    logic        beat_valid;
    logic        out_load;
    beat_t       beat;

    assign out_load = !out_valid_reg || out_ready;

    cpf_seq u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .module_address (addr_reg),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .body_byte      (body_byte),
        .first_byte     (first_byte),
        .last_byte      (last_byte),
        .packet_length  (packet_length),
        .beat_valid     (beat_valid),
        .beat_ready     (out_load),
        .beat           (beat)
    );

    assign out_valid_next = out_load ? beat_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= ADDR_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                addr_reg <= cfg_wr_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && beat_valid)
        begin
            out_byte_reg   <= beat.data;
            packet_end_reg <= beat.pkt_end;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign packet_end = packet_end_reg;

endmodule

FILE: hw/rtl/cpf_seq.sv
// ----------------------------------------------------------------------------
// cpf_seq
// Holds one input item and steps through the bytes it produces, one byte
// per cycle while beat_ready is high, keeping the running checksum.
// ----------------------------------------------------------------------------
module cpf_seq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [31:0]   module_address,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    body_byte,
    input  logic          first_byte,
    input  logic          last_byte,
    input  logic [15:0]   packet_length,
    output logic          beat_valid,
    input  logic          beat_ready,
    output cpf_pkg::beat_t beat
);
    import cpf_pkg::*;

    logic              item_valid_reg, item_valid_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [7:0]        byte_reg;
    logic              first_reg;
    logic              last_reg;
    logic [15:0]       len_reg;
    logic [15:0]       sum_reg, sum_next;
    logic              in_pkt_reg, in_pkt_next;

    logic        drop;
    logic        fire;
    logic        last_step;
    logic        done;
    logic [15:0] seed;
    logic [15:0] body_sum;

    // A continuation byte with no open packet is discarded
    assign drop = item_valid_reg && (step_reg == STEP_BODY) && !first_reg && !in_pkt_reg;
    assign beat_valid = item_valid_reg && !drop;
    assign fire = beat_valid && beat_ready;
    assign last_step = (step_reg == (last_reg ? STEP_CK_LO : STEP_BODY));
    assign done = drop || (fire && last_step);
    assign in_ready = !item_valid_reg || done;

    assign seed = {8'd0, PKT_FLAG} + {8'd0, len_reg[15:8]} + {8'd0, len_reg[7:0]};
    assign body_sum = (first_reg ? seed : sum_reg) + {8'd0, byte_reg};

    always_comb
    begin
        beat.pkt_end = (step_reg == STEP_CK_LO);
        case (step_reg)
            STEP_HDR0:   beat.data = HDR_BYTE0;
            STEP_HDR1:   beat.data = HDR_BYTE1;
            STEP_ADDR3:  beat.data = module_address[31:24];
            STEP_ADDR2:  beat.data = module_address[23:16];
            STEP_ADDR1:  beat.data = module_address[15:8];
            STEP_ADDR0:  beat.data = module_address[7:0];
            STEP_FLAG:   beat.data = PKT_FLAG;
            STEP_LEN_HI: beat.data = len_reg[15:8];
            STEP_LEN_LO: beat.data = len_reg[7:0];
            STEP_BODY:   beat.data = byte_reg;
            STEP_CK_HI:  beat.data = sum_reg[15:8];
            STEP_CK_LO:  beat.data = sum_reg[7:0];
            default:     beat.data = 8'd0;
        endcase
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        step_next       = step_reg;
        sum_next        = sum_reg;
        in_pkt_next     = in_pkt_reg;

        if (fire && (step_reg == STEP_BODY))
        begin
            sum_next    = body_sum;
            in_pkt_next = 1'b1;
        end
        else if (fire && (step_reg == STEP_CK_LO))
        begin
            sum_next    = 16'd0;
            in_pkt_next = 1'b0;
        end

        if (in_valid && in_ready)
        begin
            item_valid_next = 1'b1;
            step_next       = first_byte ? STEP_HDR0 : STEP_BODY;
        end
        else if (done)
        begin
            item_valid_next = 1'b0;
        end
        else if (fire)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            step_reg       <= STEP_HDR0;
            sum_reg        <= 16'd0;
            in_pkt_reg     <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            step_reg       <= step_next;
            sum_reg        <= sum_next;
            in_pkt_reg     <= in_pkt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg  <= body_byte;
            first_reg <= first_byte;
            last_reg  <= last_byte;
            len_reg   <= packet_length;
        end
    end

endmodule

FILE: hw/rtl/cpf_checker.sv
// ----------------------------------------------------------------------------
// cpf_checker
// Port-level checks for the command packet framer, bound to the top level.
// ----------------------------------------------------------------------------
module cpf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        first_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [7:0]  out_byte,
    input logic        packet_end
);

    // Output holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(packet_end))
        else $error("output changed while stalled");

    // A packet opener is busy with its header, so no further input is taken
    a_hdr_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && first_byte |=> !in_ready)
        else $error("input taken during header");

    // Two packet ends can never be adjacent transfers
    a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && packet_end |=> !(out_valid && packet_end))
        else $error("back-to-back packet end");

    // Nothing offered while reset is held
    a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("output valid in reset");

endmodule

bind command_packet_framer_core cpf_checker u_cpf_checker (.*);
